@@ hw/rtl/bssc_pkg.sv @@
package bssc_pkg;

  // Width of the PWM range; the counter reloads to 255 minus this on overflow
  localparam int unsigned PWM_SPAN = 255;
  localparam logic [7:0] PWM_FLOOR = 8'(255 - PWM_SPAN);
  localparam logic [7:0] PWM_TOP = 8'hFF;
  localparam logic [7:0] SPAN_MAX = 8'(PWM_SPAN);

  // Gate bit positions
  localparam logic [2:0] GATE_NONE = 3'b000;
  localparam logic [2:0] GATE_A = 3'b001;
  localparam logic [2:0] GATE_B = 3'b010;
  localparam logic [2:0] GATE_C = 3'b100;

  // PWM phase codes
  localparam logic [1:0] PHASE_NONE = 2'd0;
  localparam logic [1:0] PHASE_A = 2'd1;
  localparam logic [1:0] PHASE_B = 2'd2;
  localparam logic [1:0] PHASE_C = 2'd3;

  // Commutation step codes
  localparam logic [2:0] STEP_IDLE = 3'd0;
  localparam logic [2:0] STEP_1 = 3'd1;
  localparam logic [2:0] STEP_2 = 3'd2;
  localparam logic [2:0] STEP_3 = 3'd3;
  localparam logic [2:0] STEP_4 = 3'd4;
  localparam logic [2:0] STEP_5 = 3'd5;
  localparam logic [2:0] STEP_6 = 3'd6;
  localparam logic [2:0] STEP_7 = 3'd7;

  typedef enum logic [1:0] {
    EV_TICK = 2'd0,
    EV_COMMUTATE = 2'd1,
    EV_SET_DUTY = 2'd2,
    EV_START = 2'd3
  } event_mode_t;

  // One event as held in the input stage
  typedef struct packed {
    event_mode_t mode;
    logic [7:0] duty_value;
  } event_t;

  // Gate drive and step, as shown on the result channel
  typedef struct packed {
    logic [2:0] step_now;
    logic [2:0] low_gates;
    logic [2:0] high_gates;
  } drive_t;

  function automatic logic [2:0] phase_gate(input logic [1:0] ph);
    logic [2:0] g;
    case (ph)
      PHASE_A: g = GATE_A;
      PHASE_B: g = GATE_B;
      PHASE_C: g = GATE_C;
      default: g = GATE_NONE;
    endcase
    return g;
  endfunction

endpackage

@@ hw/rtl/bssc_state.sv @@
module bssc_state
  import bssc_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   fire,
  input  event_t ev,
  output drive_t drive_next
);

  logic [7:0] pwm_counter, pwm_counter_next;
  logic [7:0] compare_value, compare_value_next;
  logic       pwm_enabled, pwm_enabled_next;
  logic [1:0] pwm_phase, pwm_phase_next;
  logic [2:0] comm_step, comm_step_next;
  logic [2:0] high_drive, high_drive_next;
  logic [2:0] low_drive, low_drive_next;

  // Scratch values for the event update
  logic [7:0] cnt_step;
  logic [7:0] duty_clip;
  logic [2:0] old_low, new_low;
  logic [1:0] new_phase;
  logic [2:0] old_high, new_high;
  logic       odd_step;

  // Next state for the event in the input stage
  always_comb begin
    pwm_counter_next = pwm_counter;
    compare_value_next = compare_value;
    pwm_enabled_next = pwm_enabled;
    pwm_phase_next = pwm_phase;
    comm_step_next = comm_step;
    high_drive_next = high_drive;
    low_drive_next = low_drive;
    cnt_step = (pwm_counter == PWM_TOP) ? PWM_FLOOR : pwm_counter + 8'd1;
    duty_clip = (ev.duty_value > SPAN_MAX) ? SPAN_MAX : ev.duty_value;
    odd_step = 1'b1;
    old_low = GATE_C;
    new_low = GATE_B;
    new_phase = PHASE_B;
    old_high = GATE_B;
    new_high = GATE_A;

    // Step sequence: step -> (step mod 6) + 1, and the gate moves it makes
    case (comm_step)
      STEP_IDLE, STEP_6: begin
        comm_step_next = STEP_1;
      end
      STEP_1, STEP_7: begin
        comm_step_next = STEP_2;
        odd_step = 1'b0;
        old_high = GATE_A;
        new_high = GATE_C;
      end
      STEP_2: begin
        comm_step_next = STEP_3;
        old_low = GATE_B;
        new_low = GATE_A;
        new_phase = PHASE_A;
      end
      STEP_3: begin
        comm_step_next = STEP_4;
        odd_step = 1'b0;
        old_high = GATE_C;
        new_high = GATE_B;
      end
      STEP_4: begin
        comm_step_next = STEP_5;
        old_low = GATE_A;
        new_low = GATE_C;
        new_phase = PHASE_C;
      end
      default: begin
        comm_step_next = STEP_6;
        odd_step = 1'b0;
      end
    endcase

    case (ev.mode)
      EV_TICK: begin
        comm_step_next = comm_step;
        if (pwm_enabled) begin
          pwm_counter_next = cnt_step;
          if (pwm_counter == PWM_TOP) begin
            low_drive_next = low_drive | phase_gate(pwm_phase);
          end
          if (cnt_step == compare_value) begin
            low_drive_next = GATE_NONE;
          end
        end
      end
      EV_COMMUTATE: begin
        if (odd_step) begin
          pwm_phase_next = new_phase;
          if ((low_drive & old_low) != GATE_NONE) begin
            low_drive_next = (low_drive & ~old_low) | new_low;
          end
        end else begin
          high_drive_next = (high_drive & ~old_high) | new_high;
        end
      end
      EV_SET_DUTY: begin
        comm_step_next = comm_step;
        if (ev.duty_value == 8'd0) begin
          pwm_enabled_next = 1'b0;
          compare_value_next = 8'd0;
          low_drive_next = GATE_NONE;
        end else begin
          pwm_enabled_next = 1'b1;
          compare_value_next = PWM_FLOOR + duty_clip;
        end
      end
      default: begin
        comm_step_next = comm_step;
        pwm_phase_next = PHASE_B;
        high_drive_next = high_drive | GATE_A;
      end
    endcase
  end

  // State registers update when the event moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_counter <= 8'd0;
      compare_value <= 8'd0;
      pwm_enabled <= 1'b0;
      pwm_phase <= PHASE_NONE;
      comm_step <= STEP_IDLE;
      high_drive <= GATE_NONE;
      low_drive <= GATE_NONE;
    end else if (fire) begin
      pwm_counter <= pwm_counter_next;
      compare_value <= compare_value_next;
      pwm_enabled <= pwm_enabled_next;
      pwm_phase <= pwm_phase_next;
      comm_step <= comm_step_next;
      high_drive <= high_drive_next;
      low_drive <= low_drive_next;
    end
  end

  assign drive_next.high_gates = high_drive_next;
  assign drive_next.low_gates = low_drive_next;
  assign drive_next.step_now = comm_step_next;

endmodule

@@ hw/rtl/bldc_six_step_commutator_pwm.sv @@
// Channel  Dir  tdata (low bit up)                 tuser
// s_*      in   duty_value[7:0]                    mode[1:0]
// m_*      out  high_gates, low_gates, step_now    -
//
// One event per cycle sustained while m_tready stays high; each event passes the input
// register, then the result register, before its result can be taken.
// rst is synchronous: all gates off, step 0, PWM disabled, both stages empty.
// A stall on m_tready holds the result; s_tready stays high while either
// stage can move, so a new event enters while a finished result waits.
module bldc_six_step_commutator_pwm
  import bssc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // duty_value[7:0]
  input  logic [1:0]  s_tuser,   // mode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // high_gates[2:0], low_gates[5:3], step_now[8:6], zero pad
);

  event_t in_ev;
  logic   in_valid;
  logic   fire;
  drive_t drive_next;
  drive_t out_drive;

  // Result register moves when empty or being taken
  assign fire = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;

  // Input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_ev.mode <= event_mode_t'(s_tuser);
      in_ev.duty_value <= s_tdata;
    end
  end

  bssc_state u_state (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .ev         (in_ev),
    .drive_next (drive_next)
  );

  // Result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_drive <= drive_next;
    end
  end

  assign m_tdata = {7'd0, out_drive.step_now, out_drive.low_gates, out_drive.high_gates};

endmodule

@@ sim/bldc_six_step_commutator_pwm_tb.sv @@
`timescale 1ns / 1ps

module bldc_six_step_commutator_pwm_tb;
  import bssc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [7:0] COUNT_FLOOR = 8'(255 - PWM_SPAN);

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;   // duty_value[7:0]
  logic [1:0]  s_tuser = 2'd0;   // mode[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;          // high_gates[2:0], low_gates[5:3], step_now[8:6], zero pad

  // Predictor state
  logic [7:0] pred_counter;
  logic [7:0] pred_compare;
  bit         pred_pwm_on;
  logic [1:0] pred_phase;
  logic [2:0] pred_step;
  logic [2:0] pred_high;
  logic [2:0] pred_low;

  drive_t drive_expected[$];
  int     error_count = 0;
  int     idle_cycles = 0;
  int     ready_hold = 0;
  bit     calm = 1'b0;

  bldc_six_step_commutator_pwm u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [2:0] low_gate_for(input logic [1:0] ph);
    case (ph)
      PHASE_A: return GATE_A;
      PHASE_B: return GATE_B;
      PHASE_C: return GATE_C;
      default: return GATE_NONE;
    endcase
  endfunction

  // Odd step: PWM moves to a new low side, keeping its on state
  function automatic void shift_low(input logic [2:0] old_g, input logic [2:0] new_g,
                                    input logic [1:0] new_ph);
    if ((pred_low & old_g) != GATE_NONE) pred_low = (pred_low & ~old_g) | new_g;
    pred_phase = new_ph;
  endfunction

  // Apply one event to the predictor and return the gate drive it shows
  function automatic drive_t predict_drive(input event_mode_t mode, input logic [7:0] duty);
    drive_t d;
    logic [7:0] clipped;
    case (mode)
      EV_TICK: begin
        if (pred_pwm_on) begin
          if (pred_counter == PWM_TOP) begin
            pred_counter = COUNT_FLOOR;
            pred_low = pred_low | low_gate_for(pred_phase);
          end else begin
            pred_counter = pred_counter + 8'd1;
          end
          if (pred_counter == pred_compare) pred_low = GATE_NONE;
        end
      end
      EV_COMMUTATE: begin
        pred_step = 3'((pred_step % 6) + 1);
        case (pred_step)
          STEP_1: shift_low(GATE_C, GATE_B, PHASE_B);
          STEP_2: pred_high = (pred_high & ~GATE_A) | GATE_C;
          STEP_3: shift_low(GATE_B, GATE_A, PHASE_A);
          STEP_4: pred_high = (pred_high & ~GATE_C) | GATE_B;
          STEP_5: shift_low(GATE_A, GATE_C, PHASE_C);
          default: pred_high = (pred_high & ~GATE_B) | GATE_A;
        endcase
      end
      EV_SET_DUTY: begin
        if (duty == 8'd0) begin
          pred_pwm_on = 1'b0;
          pred_compare = 8'd0;
          pred_low = GATE_NONE;
        end else begin
          clipped = (duty > 8'(PWM_SPAN)) ? 8'(PWM_SPAN) : duty;
          pred_pwm_on = 1'b1;
          pred_compare = COUNT_FLOOR + clipped;
        end
      end
      default: begin
        pred_phase = PHASE_B;
        pred_high = pred_high | GATE_A;
      end
    endcase
    d.high_gates = pred_high;
    d.low_gates = pred_low;
    d.step_now = pred_step;
    return d;
  endfunction

  // Send one event, with an occasional random gap before it
  task automatic send_event(input event_mode_t mode, input logic [7:0] duty);
    int gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 17);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= duty;
    do @(posedge clk); while (!s_tready);
    drive_expected.push_back(predict_drive(mode, duty));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (drive_expected.size() != 0) @(posedge clk);
  endtask

  // Random event mix; tick_weight percent are ticks, so a high weight lets the counter wrap
  task automatic send_random_event(input int tick_weight);
    int pick;
    logic [7:0] duty;
    pick = $urandom_range(0, 99);
    duty = 8'($urandom_range(0, 255));
    if (pick < tick_weight) send_event(EV_TICK, duty);
    else if (pick < tick_weight + (100 - tick_weight) / 3) send_event(EV_COMMUTATE, duty);
    else if (pick < 97) send_event(EV_SET_DUTY, ($urandom_range(0, 5) == 0) ? 8'd0 : duty);
    else send_event(EV_START, duty);
  endtask

  // Directed: disabled ticks, full commutation cycle with wrap, duty extremes
  task automatic test_directed_events();
    send_event(EV_TICK, 8'hFF);
    repeat (7) send_event(EV_COMMUTATE, 8'h00);
    send_event(EV_START, 8'hAA);
    send_event(EV_SET_DUTY, 8'd0);
    send_event(EV_TICK, 8'd0);
    send_event(EV_SET_DUTY, 8'd255);
    repeat (3) send_event(EV_TICK, 8'h55);
    send_event(EV_SET_DUTY, 8'd1);
    send_event(EV_SET_DUTY, 8'd128);
    send_event(EV_TICK, 8'd0);
    send_event(EV_COMMUTATE, 8'd0);
    send_event(EV_START, 8'd0);
    send_event(EV_SET_DUTY, 8'd4);
    send_event(EV_TICK, 8'd0);
    send_event(EV_SET_DUTY, 8'd0);
  endtask

  // Start, set a duty, then long runs of ticks with occasional commutation
  task automatic test_drive_sequences(input int runs);
    int len;
    for (int r = 0; r < runs; r++) begin
      send_event(EV_START, 8'($urandom_range(0, 255)));
      send_event(EV_SET_DUTY, 8'($urandom_range(1, 255)));
      len = $urandom_range(200, 320);
      for (int i = 0; i < len; i++) begin
        send_random_event(94);
      end
    end
  endtask

  // Unstructured mix of all events
  task automatic test_random_mix(input int count);
    for (int i = 0; i < count; i++) send_random_event(40);
  endtask

  // Sender holds off until every result is back, then resumes
  task automatic test_drain_pause();
    send_event(EV_START, 8'd0);
    send_event(EV_SET_DUTY, 8'd200);
    repeat (20) send_random_event(80);
    wait_drained();
    repeat (20) send_random_event(80);
  endtask

  // No idling on either side for the last stretch
  task automatic test_steady_stream(input int count);
    calm = 1'b1;
    send_event(EV_SET_DUTY, 8'($urandom_range(1, 255)));
    for (int i = 0; i < count; i++) send_random_event(92);
  endtask

  // Result side: random stall bursts
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      m_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      ready_hold <= $urandom_range(0, 16);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Compare each result transfer with the oldest expectation
  drive_t want;
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (drive_expected.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, m_tdata);
        error_count++;
      end else begin
        want = drive_expected.pop_front();
        if (m_tdata[2:0] !== want.high_gates) begin
          $display("%0t: high_gates expected %b actual %b", $time, want.high_gates,
                   m_tdata[2:0]);
          error_count++;
        end
        if (m_tdata[5:3] !== want.low_gates) begin
          $display("%0t: low_gates expected %b actual %b", $time, want.low_gates,
                   m_tdata[5:3]);
          error_count++;
        end
        if (m_tdata[8:6] !== want.step_now) begin
          $display("%0t: step_now expected %0d actual %0d", $time, want.step_now,
                   m_tdata[8:6]);
          error_count++;
        end
        if (m_tdata[15:9] !== 7'd0) begin
          $display("%0t: pad bits expected 0 actual %h", $time, m_tdata[15:9]);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    pred_counter = 8'd0;
    pred_compare = 8'd0;
    pred_pwm_on = 1'b0;
    pred_phase = PHASE_NONE;
    pred_step = STEP_IDLE;
    pred_high = GATE_NONE;
    pred_low = GATE_NONE;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_events();
    test_drive_sequences(4);
    test_drain_pause();
    test_random_mix(300);
    test_drive_sequences(1);
    test_steady_stream(240);

    s_tvalid <= 1'b0;
    while (drive_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
